FILE: rtl/dlss_pkg.sv
// ----------------------------------------------------------------------------
// dlss_pkg
// Shared types, constants and symbol/bin mapping for the digit/letter sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dlss_pkg;

    localparam int CHAR_W        = 8;
    localparam int NBINS         = 62;
    localparam int DIGIT_BINS    = 10;
    localparam int LETTER_BINS   = 26;
    localparam int BIN_W         = 6;
    localparam int MAX_CHARS_DEF = 1024;

    // Priority tree geometry: 8 leaf groups of 8 bins each
    localparam int LEAF_N  = 8;
    localparam int NGRP    = 8;
    localparam int LEAF_W  = 3;
    localparam int PAD_W   = NGRP * LEAF_N;

    // Input kind codes
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    // Output group codes
    localparam logic GRP_DIGIT  = 1'b0;
    localparam logic GRP_LETTER = 1'b1;

    // Decoded symbol
    typedef struct packed {
        logic             hit;
        logic             grp;
        logic [BIN_W-1:0] bin;
    } bin_dec_t;

    // Count store write command
    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
    } wr_cmd_t;

    // Byte -> bin: digits 0..9, 'z'..'a' 10..35, 'Z'..'A' 36..61
    function automatic bin_dec_t bin_of(input logic [CHAR_W-1:0] c);
        bin_dec_t d;
        logic [CHAR_W-1:0] t;
        d = '0;
        t = '0;
        if (c >= 8'd48 && c <= 8'd57)
        begin
            t     = c - 8'd48;
            d.hit = 1'b1;
            d.grp = GRP_DIGIT;
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            t     = 8'd132 - c;
            d.hit = 1'b1;
            d.grp = GRP_LETTER;
        end
        else if (c >= 8'd65 && c <= 8'd90)
        begin
            t     = 8'd126 - c;
            d.hit = 1'b1;
            d.grp = GRP_LETTER;
        end
        d.bin = t[BIN_W-1:0];
        return d;
    endfunction

    // Bin -> byte
    function automatic logic [CHAR_W-1:0] char_of(input logic [BIN_W-1:0] b);
        logic [CHAR_W-1:0] w;
        logic [CHAR_W-1:0] r;
        w = {2'b00, b};
        if (b < 6'd10)
        begin
            r = 8'd48 + w;
        end
        else if (b < 6'd36)
        begin
            r = 8'd132 - w;
        end
        else
        begin
            r = 8'd126 - w;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dlss_count_store.sv
// ----------------------------------------------------------------------------
// dlss_count_store
// Per-symbol count memory with reset-cleared valid bits and nonzero flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dlss_count_store #(
    parameter int CNT_W = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [dlss_pkg::BIN_W-1:0]   rd_addr,
    input  wire dlss_pkg::wr_cmd_t            wr,
    input  wire logic [CNT_W-1:0]             wr_data,
    output logic      [CNT_W-1:0]             rd_count,
    output logic      [dlss_pkg::NBINS-1:0]   nz
);
    import dlss_pkg::*;

    logic [CNT_W-1:0] mem [NBINS];
    logic [CNT_W-1:0] rd_data_reg;
    logic [NBINS-1:0] vld_reg;
    logic [NBINS-1:0] nz_reg;
    logic             rd_vld_reg;

    // Memory array: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid and nonzero flags per bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            nz_reg     <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
                nz_reg[wr.addr]  <= (wr_data != '0);
            end
        end
    end

    // Entry never written reads as zero
    assign rd_count = rd_vld_reg ? rd_data_reg : '0;
    assign nz       = nz_reg;

endmodule

`default_nettype wire

FILE: rtl/dlss_find.sv
// ----------------------------------------------------------------------------
// dlss_find
// Two-level registered priority search for the lowest nonzero bin.
// ----------------------------------------------------------------------------
`default_nettype none

module dlss_find (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [dlss_pkg::NBINS-1:0]  nz,
    output logic                             any,
    output logic      [dlss_pkg::BIN_W-1:0]  bin
);
    import dlss_pkg::*;

    logic [PAD_W-1:0]  nz_pad;
    logic [NGRP-1:0]   leaf_any_reg;
    logic [LEAF_W-1:0] leaf_idx_reg [NGRP];
    logic [NGRP-1:0]   leaf_any_next;
    logic [LEAF_W-1:0] leaf_idx_next [NGRP];
    logic [LEAF_W-1:0] sel;

    assign nz_pad = {{(PAD_W-NBINS){1'b0}}, nz};

    // Leaf level: first set bit in each group of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            leaf_any_next[g] = |nz_pad[g*LEAF_N +: LEAF_N];
            leaf_idx_next[g] = '0;
            for (int k = LEAF_N-1; k >= 0; k--)
            begin
                if (nz_pad[g*LEAF_N + k])
                begin
                    leaf_idx_next[g] = LEAF_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_any_reg <= '0;
            for (int g = 0; g < NGRP; g++)
            begin
                leaf_idx_reg[g] <= '0;
            end
        end
        else
        begin
            leaf_any_reg <= leaf_any_next;
            for (int g = 0; g < NGRP; g++)
            begin
                leaf_idx_reg[g] <= leaf_idx_next[g];
            end
        end
    end

    // Root level: first group with a hit
    always_comb
    begin
        sel = '0;
        for (int g = NGRP-1; g >= 0; g--)
        begin
            if (leaf_any_reg[g])
            begin
                sel = LEAF_W'(g);
            end
        end
    end

    assign any = |leaf_any_reg;
    assign bin = {sel, leaf_idx_reg[sel]};

endmodule

`default_nettype wire

FILE: rtl/dlss_step.sv
// ----------------------------------------------------------------------------
// dlss_step
// Shared count step unit: adds or removes one from a bin count.
// ----------------------------------------------------------------------------
`default_nettype none

module dlss_step #(
    parameter int CNT_W = 10
) (
    input  wire logic             dec,
    input  wire logic [CNT_W-1:0] count,
    output logic      [CNT_W-1:0] result
);
    import dlss_pkg::*;

    // Two's complement step of +1 or -1
    assign result = count + (dec ? {CNT_W{1'b1}} : CNT_W'(1));

endmodule

`default_nettype wire

FILE: rtl/digit_letter_split_sort_core.sv
// ----------------------------------------------------------------------------
// digit_letter_split_sort_core
// Counting sort of digits and letters: loads bump a per-symbol count, pulls
// return digits ascending, then letters from 'z' down to 'A'.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                     Content
//  s_*      in   tvalid tready tdata tuser   tdata[7:0] char_in; tuser kind
//  m_*      out  tvalid tready tdata tuser   tdata[7:0] char_out, [8] valid_res;
//                tlast                       tuser group; tlast last
//
//  Load: one count memory read, then one write through the shared step
//  unit; a dropped byte or a full group does neither.
//  Pull: priority tree stage, root select and memory read, step and
//  write-back, then the output register; an empty pull skips the step.
//  A pull waits in its final cycle while the output register holds an
//  item not yet taken. Reset clears all counts at once via valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_letter_split_sort_core #(
    parameter int MAX_CHARS = dlss_pkg::MAX_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] char_out, [8] valid_res, zero pad
    output logic             m_tuser,   // [0] group
    output logic             m_tlast
);
    import dlss_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARS);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_CHARS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LWR,
        S_P1,
        S_P2,
        S_POUT
    } state_t;

    state_t            state_reg;
    logic [BIN_W-1:0]  bin_reg;
    logic              grp_reg;
    logic              found_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  dig_tot_reg;
    logic [CNT_W-1:0]  let_tot_reg;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic              m_found_reg;
    logic              m_grp_reg;
    logic              m_last_reg;

    bin_dec_t          dec_in;
    logic              in_acc;
    logic              out_free;
    logic [CNT_W-1:0]  grp_tot;
    logic [BIN_W-1:0]  rd_addr;
    wr_cmd_t           wr;
    logic [CNT_W-1:0]  rd_count;
    logic [CNT_W-1:0]  step_res;
    logic [NBINS-1:0]  nz;
    logic              f_any;
    logic [BIN_W-1:0]  f_bin;
    logic              step_dec;

    assign dec_in   = bin_of(s_tdata);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign grp_tot  = (dec_in.grp == GRP_LETTER) ? let_tot_reg : dig_tot_reg;
    assign s_tready = (state_reg == S_IDLE);

    // Read address: decoded byte on a load, tree result on a pull
    assign rd_addr  = (state_reg == S_P1) ? f_bin : dec_in.bin;
    assign step_dec = (state_reg == S_P2);

    // Write-back in the step cycle of either operation
    assign wr.en    = (state_reg == S_LWR) || (state_reg == S_P2);
    assign wr.addr  = bin_reg;

    dlss_count_store #(.CNT_W(CNT_W)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .wr       (wr),
        .wr_data  (step_res),
        .rd_count (rd_count),
        .nz       (nz)
    );

    dlss_find u_find (
        .clk   (clk),
        .rst_n (rst_n),
        .nz    (nz),
        .any   (f_any),
        .bin   (f_bin)
    );

    dlss_step #(.CNT_W(CNT_W)) u_step (
        .dec    (step_dec),
        .count  (rd_count),
        .result (step_res)
    );

    // Sequencer, group totals and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bin_reg     <= '0;
            grp_reg     <= 1'b0;
            found_reg   <= 1'b0;
            last_reg    <= 1'b0;
            dig_tot_reg <= '0;
            let_tot_reg <= '0;
            m_valid_reg <= 1'b0;
            m_char_reg  <= '0;
            m_found_reg <= 1'b0;
            m_grp_reg   <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            // In S_POUT the output register is reloaded below whenever it drains
            if (m_valid_reg && m_tready && (state_reg != S_POUT))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_tuser == KIND_PULL)
                        begin
                            state_reg <= S_P1;
                        end
                        else if (dec_in.hit && (grp_tot < CAP))
                        begin
                            bin_reg   <= dec_in.bin;
                            grp_reg   <= dec_in.grp;
                            state_reg <= S_LWR;
                        end
                    end
                end

                S_LWR:
                begin
                    if (grp_reg == GRP_LETTER)
                    begin
                        let_tot_reg <= let_tot_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dig_tot_reg <= dig_tot_reg + CNT_W'(1);
                    end
                    state_reg <= S_IDLE;
                end

                S_P1:
                begin
                    bin_reg   <= f_bin;
                    grp_reg   <= (f_bin < BIN_W'(DIGIT_BINS)) ? GRP_DIGIT : GRP_LETTER;
                    found_reg <= f_any;
                    last_reg  <= 1'b0;
                    state_reg <= f_any ? S_P2 : S_POUT;
                end

                S_P2:
                begin
                    // Last when both totals reach zero after this removal
                    if (grp_reg == GRP_LETTER)
                    begin
                        let_tot_reg <= let_tot_reg - CNT_W'(1);
                        last_reg    <= (let_tot_reg == CNT_W'(1)) && (dig_tot_reg == '0);
                    end
                    else
                    begin
                        dig_tot_reg <= dig_tot_reg - CNT_W'(1);
                        last_reg    <= (dig_tot_reg == CNT_W'(1)) && (let_tot_reg == '0);
                    end
                    state_reg <= S_POUT;
                end

                S_POUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_found_reg <= found_reg;
                        m_char_reg  <= found_reg ? char_of(bin_reg) : '0;
                        m_grp_reg   <= found_reg && grp_reg;
                        m_last_reg  <= found_reg && last_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_found_reg, m_char_reg};
    assign m_tuser  = m_grp_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: rtl/dlss_checker.sv
// ----------------------------------------------------------------------------
// dlss_checker
// Port-level checks on the sorter's output items, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dlss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    import dlss_pkg::*;

    // Empty pull gives an all-zero item
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[8]) |->
            (m_tdata[7:0] == 8'd0) && !m_tuser && !m_tlast)
        else $error("empty item carries nonzero fields");

    // Digit group holds only '0'..'9'
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8] && (m_tuser == GRP_DIGIT)) |->
            (m_tdata[7:0] >= 8'd48) && (m_tdata[7:0] <= 8'd57))
        else $error("digit group item out of range");

    // Letter group holds only ASCII letters
    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8] && (m_tuser == GRP_LETTER)) |->
            (((m_tdata[7:0] >= 8'd65) && (m_tdata[7:0] <= 8'd90)) ||
             ((m_tdata[7:0] >= 8'd97) && (m_tdata[7:0] <= 8'd122))))
        else $error("letter group item out of range");

    // Stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output item changed while stalled");

endmodule

bind digit_letter_split_sort_core dlss_checker u_dlss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the digit/letter counting sorter. A table of
// directed items covers the byte classes and their edges. Random bursts of
// loads, pulls and drains follow, then a pass that fills the digit group past
// its cap. Directed pulls are checked against their table row, the others
// against a local count-store predictor. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import dlss_pkg::*;

    localparam int MAX_CHARS   = MAX_CHARS_DEF;
    localparam int GROUP_CAP   = MAX_CHARS - 1;
    localparam int RAND_ITEMS  = 200;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_PULLS  = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int END_PULLS   = 8;
    localparam int END_WAIT    = 20;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 40;

    // Expected fields of one pull result
    typedef struct packed {
        logic [7:0] ch;
        logic       grp;
        logic       hit;
        logic       fin;
    } sort_out_t;

    // One row of the directed table
    typedef struct {
        logic       kind;
        logic [7:0] ch;
        bit         typed;
        sort_out_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_in
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] char_out, [8] valid_res, zero pad
    logic        m_tuser;   // [0] group
    logic        m_tlast;

    // Predictor state: one count per symbol slot plus group totals
    int unsigned sym_count [NBINS];
    int unsigned digit_total = 0;
    int unsigned letter_total = 0;

    sort_out_t   pending_out [$];
    stim_row_t   dir_rows [$];

    int err_count = 0;
    int cyc_count = 0;
    int snd_run   = 0;
    int rcv_run   = 0;
    bit snd_calm  = 1'b0;
    bit rcv_calm  = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_ack  = 1'b0;

    digit_letter_split_sort_core #(
        .MAX_CHARS(MAX_CHARS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Slot of a byte: digits 0..9, 'z'..'a' next, 'Z'..'A' last; -1 if dropped
    function automatic int sym_slot(logic [7:0] c);
        int v;
        v = int'(c);
        if (v >= 48 && v <= 57)
        begin
            return v - 48;
        end
        if (v >= 97 && v <= 122)
        begin
            return DIGIT_BINS + (122 - v);
        end
        if (v >= 65 && v <= 90)
        begin
            return DIGIT_BINS + LETTER_BINS + (90 - v);
        end
        return -1;
    endfunction

    function automatic logic [7:0] slot_char(int s);
        int v;
        if (s < DIGIT_BINS)
        begin
            v = 48 + s;
        end
        else if (s < DIGIT_BINS + LETTER_BINS)
        begin
            v = 122 - (s - DIGIT_BINS);
        end
        else
        begin
            v = 90 - (s - DIGIT_BINS - LETTER_BINS);
        end
        return v[7:0];
    endfunction

    // Advance the count store by one item; returns 1 when a result is due
    function automatic bit sort_step(logic kind, logic [7:0] c, output sort_out_t res);
        int s;
        res = '0;
        if (kind == KIND_LOAD)
        begin
            s = sym_slot(c);
            if (s >= 0 && s < DIGIT_BINS && digit_total < GROUP_CAP)
            begin
                sym_count[s]++;
                digit_total++;
            end
            else if (s >= DIGIT_BINS && letter_total < GROUP_CAP)
            begin
                sym_count[s]++;
                letter_total++;
            end
            return 1'b0;
        end
        // pull: lowest nonzero slot wins
        for (s = 0; s < NBINS; s++)
        begin
            if (sym_count[s] != 0)
            begin
                break;
            end
        end
        if (s == NBINS)
        begin
            return 1'b1;
        end
        sym_count[s]--;
        if (s < DIGIT_BINS)
        begin
            digit_total--;
        end
        else
        begin
            letter_total--;
        end
        res.ch  = slot_char(s);
        res.grp = (s < DIGIT_BINS) ? GRP_DIGIT : GRP_LETTER;
        res.hit = 1'b1;
        res.fin = (digit_total + letter_total == 0);
        return 1'b1;
    endfunction

    // Wait draw, with stretches of back-to-back items
    function automatic int next_gap(ref int run_left, ref bit calm);
        if (run_left == 0)
        begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(8, 60);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] rand_byte(int lo, int hi);
        int v;
        v = $urandom_range(hi, lo);
        return v[7:0];
    endfunction

    function automatic logic [7:0] rand_letter();
        int v;
        v = $urandom_range(0, 51);
        v = (v < 26) ? 97 + v : 65 + v - 26;
        return v[7:0];
    endfunction

    // Mostly digits and letters, some arbitrary bytes
    function automatic logic [7:0] rand_text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return rand_byte(48, 57);
            3, 4, 5, 6: return rand_letter();
            default: return rand_byte(0, 255);
        endcase
    endfunction

    task automatic add_row(logic kind, logic [7:0] c, bit typed, sort_out_t want);
        stim_row_t r;
        r.kind  = kind;
        r.ch    = c;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        if (err_count < MAX_PRINTS)
        begin
            $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want,
                     cyc_count);
        end
        err_count++;
    endtask

    // Offer one item, wait for the handshake, then update the predictor
    task automatic push_item(logic kind, logic [7:0] c, bit typed, sort_out_t want);
        int gap;
        sort_out_t res;
        gap = next_gap(snd_run, snd_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        if (sort_step(kind, c, res))
        begin
            pending_out.push_back(typed ? want : res);
        end
    endtask

    task automatic push_pull();
        push_item(KIND_PULL, rand_byte(0, 255), 1'b0, '0);
    endtask

    // Stimulus
    initial
    begin
        int n;
        int burst;
        int rand_count;
        bit hold_done;
        logic [7:0] c;
        stim_row_t r;

        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_LOAD;
        for (n = 0; n < NBINS; n++)
        begin
            sym_count[n] = 0;
        end

        // directed: empty pull, group edges, dropped byte classes, drain
        add_row(KIND_PULL, 8'h00, 1'b1, '0);
        add_row(KIND_LOAD, 8'h30, 1'b0, '0);   // '0'
        add_row(KIND_LOAD, 8'h39, 1'b0, '0);   // '9'
        add_row(KIND_LOAD, 8'h61, 1'b0, '0);   // 'a'
        add_row(KIND_LOAD, 8'h7A, 1'b0, '0);   // 'z'
        add_row(KIND_LOAD, 8'h41, 1'b0, '0);   // 'A'
        add_row(KIND_LOAD, 8'h5A, 1'b0, '0);   // 'Z'
        add_row(KIND_LOAD, 8'h00, 1'b0, '0);   // NUL
        add_row(KIND_LOAD, 8'hFF, 1'b0, '0);
        add_row(KIND_LOAD, 8'hB0, 1'b0, '0);   // '0' with bit 7 set
        add_row(KIND_LOAD, 8'h2F, 1'b0, '0);   // just below '0'
        add_row(KIND_LOAD, 8'h3A, 1'b0, '0);   // just above '9'
        add_row(KIND_LOAD, 8'h40, 1'b0, '0);   // just below 'A'
        add_row(KIND_LOAD, 8'h5B, 1'b0, '0);   // just above 'Z'
        add_row(KIND_LOAD, 8'h60, 1'b0, '0);   // just below 'a'
        add_row(KIND_LOAD, 8'h7B, 1'b0, '0);   // just above 'z'
        add_row(KIND_LOAD, 8'h20, 1'b0, '0);   // space
        add_row(KIND_PULL, 8'h30, 1'b1, {8'h30, GRP_DIGIT, 1'b1, 1'b0});
        add_row(KIND_PULL, 8'hFF, 1'b1, {8'h39, GRP_DIGIT, 1'b1, 1'b0});
        add_row(KIND_PULL, 8'h00, 1'b1, {8'h7A, GRP_LETTER, 1'b1, 1'b0});
        add_row(KIND_PULL, 8'h5A, 1'b1, {8'h61, GRP_LETTER, 1'b1, 1'b0});
        add_row(KIND_PULL, 8'h00, 1'b1, {8'h5A, GRP_LETTER, 1'b1, 1'b0});
        add_row(KIND_PULL, 8'hA5, 1'b1, {8'h41, GRP_LETTER, 1'b1, 1'b1});
        add_row(KIND_PULL, 8'h00, 1'b1, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            push_item(r.kind, r.ch, r.typed, r.want);
        end

        // random bursts of loads, pulls and full drains
        rand_count = 0;
        hold_done  = 1'b0;
        while (rand_count < RAND_ITEMS)
        begin
            if (!hold_done && rand_count >= HOLD_AT)
            begin
                // output side stalls while pulls keep coming
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (HOLD_PULLS) push_pull();
                rand_count += HOLD_PULLS;
            end
            burst = $urandom_range(0, 9);
            if (burst < 5)
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    c = rand_text_byte();
                    push_item(KIND_LOAD, c, 1'b0, '0);
                    if (sym_slot(c) >= 0)
                    begin
                        rand_count++;
                    end
                end
            end
            else if (burst < 9)
            begin
                n = $urandom_range(1, 15);
                repeat (n) push_pull();
                rand_count += n;
            end
            else
            begin
                while (digit_total + letter_total > 0)
                begin
                    push_pull();
                    rand_count++;
                end
                n = $urandom_range(1, 2);
                repeat (n) push_pull();
                rand_count += n;
            end
        end

        // digit group to its cap, over it, one step back, and over again
        while (digit_total < GROUP_CAP)
        begin
            push_item(KIND_LOAD, rand_byte(48, 57), 1'b0, '0);
        end
        repeat (4) push_item(KIND_LOAD, rand_byte(48, 57), 1'b0, '0);
        push_pull();
        repeat (2) push_item(KIND_LOAD, rand_byte(48, 57), 1'b0, '0);

        // letters still load while the digit group stays full
        repeat (4) push_item(KIND_LOAD, rand_letter(), 1'b0, '0);
        repeat (2) push_item(KIND_LOAD, rand_byte(48, 57), 1'b0, '0);

        // a few pulls from the full store
        repeat (END_PULLS) push_pull();

        s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (err_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Output side: random ready, plus one long stall on request
    initial
    begin
        int w;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req && !hold_ack)
            begin
                hold_ack = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            w = next_gap(rcv_run, rcv_calm);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        sort_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_out.size() == 0)
            begin
                flag_mismatch("unexpected item", int'(m_tdata), 0);
            end
            else
            begin
                want = pending_out.pop_front();
                if (m_tdata[7:0] != want.ch)
                begin
                    flag_mismatch("char_out", int'(m_tdata[7:0]), int'(want.ch));
                end
                if (m_tdata[8] != want.hit)
                begin
                    flag_mismatch("valid_res", int'(m_tdata[8]), int'(want.hit));
                end
                if (m_tdata[15:9] != '0)
                begin
                    flag_mismatch("tdata pad", int'(m_tdata[15:9]), 0);
                end
                if (m_tuser != want.grp)
                begin
                    flag_mismatch("group", int'(m_tuser), int'(want.grp));
                end
                if (m_tlast != want.fin)
                begin
                    flag_mismatch("last", int'(m_tlast), int'(want.fin));
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
rtl/dlss_pkg.sv
rtl/dlss_count_store.sv
rtl/dlss_find.sv
rtl/dlss_step.sv
rtl/digit_letter_split_sort_core.sv
rtl/dlss_checker.sv
tb/sv/tb_top.sv
